[design/satrs_pkg.sv]
package satrs_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 8'd1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_RECT   = 2'd1;
  localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD_WR,
    ST_Q_TR,
    ST_Q_BL,
    ST_Q_TL,
    ST_Q_ACC,
    ST_Q_OUT
  } state_t;

  // which entry of the bordered table a read fetches: the entry above for a load, or a corner
  typedef enum logic [2:0] {
    RD_ABOVE,
    RD_BR,
    RD_TR,
    RD_BL,
    RD_TL
  } rd_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SET,
    ACC_SUB,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_t rd_sel;
    acc_op_t acc_op;
    logic    load_wr;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic load_ok;
    logic query_ok;
    logic out_free;
  } stat_t;

endpackage

[design/summed_area_table_region_sum_unit.sv]
// channel  dir  handshake                       payload
// s_axis   in   s_axis_tvalid / s_axis_tready   tdata: elem, top, left, bottom, right
//                                               tuser: func (0 load, 1 query)
// m_axis   out  m_axis_tvalid / m_axis_tready   tdata: region_sum, status
// cfg      in   cfg_valid / cfg_ready           cfg_index, cfg_data
//
// A load item steps through accept, read of the entry above, and write. A query
// steps through accept, check, four table reads with one subtract/add per returned
// word, and the output register load. A load into a full table ends after the check;
// a rejected query goes from the check to the output register load (no table reads).
// A query whose result cannot enter the output register waits in its last step.
// Reset is synchronous and holds both readies low; the table memory is not cleared.
module summed_area_table_region_sum_unit #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] element_value, [21:16] top_row, [27:22] left_column,
  // [33:28] bottom_row, [39:34] right_column
  input  logic [satrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] region_sum, [33:32] status, [39:34] zero
  output logic [satrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [satrs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [satrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  satrs_pkg::cmd_t  cmd;
  satrs_pkg::stat_t stat;

  assign cfg_ready = !rst;

  satrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  satrs_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_func   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // no table access while waiting for an item
  a_idle_no_mem: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !cmd.rd_en && !cmd.load_wr)
    else $error("table access while idle");

  // a pending result is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");

  // a table write always follows the read of the entry above
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load_wr |-> $past(cmd.rd_en) && ($past(cmd.rd_sel) == satrs_pkg::RD_ABOVE))
    else $error("table write without preceding read");

endmodule

[design/satrs_ctrl.sv]
module satrs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  satrs_pkg::stat_t stat,
  output satrs_pkg::cmd_t  cmd
);

  satrs_pkg::state_t state;
  satrs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= satrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.latch    = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.rd_sel   = satrs_pkg::RD_BR;
    cmd.acc_op   = satrs_pkg::ACC_HOLD;
    cmd.load_wr  = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      satrs_pkg::ST_IDLE: begin
        // no item is taken while reset is held
        in_ready  = !rst;
        cmd.latch = in_valid && !rst;
        if (in_valid && !rst) begin
          state_next = satrs_pkg::ST_EXEC;
        end
      end
      satrs_pkg::ST_EXEC: begin
        if (stat.is_query) begin
          if (stat.query_ok) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = satrs_pkg::RD_BR;
            state_next = satrs_pkg::ST_Q_TR;
          end else begin
            state_next = satrs_pkg::ST_Q_OUT;
          end
        end else if (stat.load_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = satrs_pkg::RD_ABOVE;
          state_next = satrs_pkg::ST_LOAD_WR;
        end else begin
          state_next = satrs_pkg::ST_IDLE;
        end
      end
      satrs_pkg::ST_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = satrs_pkg::ST_IDLE;
      end
      // each of Q_TR, Q_BL and Q_TL issues one read and folds in the data of the previous one
      satrs_pkg::ST_Q_TR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = satrs_pkg::RD_TR;
        cmd.acc_op = satrs_pkg::ACC_SET;
        state_next = satrs_pkg::ST_Q_BL;
      end
      satrs_pkg::ST_Q_BL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = satrs_pkg::RD_BL;
        cmd.acc_op = satrs_pkg::ACC_SUB;
        state_next = satrs_pkg::ST_Q_TL;
      end
      satrs_pkg::ST_Q_TL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = satrs_pkg::RD_TL;
        cmd.acc_op = satrs_pkg::ACC_SUB;
        state_next = satrs_pkg::ST_Q_ACC;
      end
      satrs_pkg::ST_Q_ACC: begin
        cmd.acc_op = satrs_pkg::ACC_ADD;
        state_next = satrs_pkg::ST_Q_OUT;
      end
      satrs_pkg::ST_Q_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = satrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = satrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/satrs_dp.sv]
module satrs_dp #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [satrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [satrs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [satrs_pkg::IN_DATA_W-1:0]     in_data,
  input  logic                                in_func,
  input  satrs_pkg::cmd_t                     cmd,
  output satrs_pkg::stat_t                    stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [satrs_pkg::OUT_DATA_W-1:0]    out_data
);

  localparam int RowAw = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColAw = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int Aw    = RowAw + ColAw;
  localparam int Depth = 1 << Aw;

  logic [6:0]  row_count;
  logic [6:0]  column_count;
  logic [6:0]  rows_used;
  logic [6:0]  cols_used;

  logic        item_func;
  logic [15:0] item_elem;
  logic [5:0]  item_top;
  logic [5:0]  item_left;
  logic [5:0]  item_bottom;
  logic [5:0]  item_right;

  logic [6:0]  load_row;
  logic [6:0]  load_column;
  logic [31:0] row_running_sum;
  logic        table_full;

  logic [31:0] mem [Depth];
  logic [31:0] rd_data;
  logic        rd_zero;
  logic [31:0] rd_value;
  logic [6:0]  rd_row;
  logic [6:0]  rd_col;
  logic        rd_border;
  logic [Aw-1:0] rd_addr;
  logic [Aw-1:0] wr_addr;

  logic [31:0] elem_ext;
  logic [31:0] rrs_sum;
  logic [31:0] wr_data;
  logic [6:0]  col_inc;
  logic [6:0]  row_inc;

  logic [31:0] acc;
  logic [1:0]  q_status;
  logic        rect_bad;
  logic [31:0] out_sum;
  logic [1:0]  out_status;
  logic        cfg_restart;

  // zero acts as one, anything above the table size saturates
  always_comb begin
    if (row_count == 7'd0) begin
      rows_used = 7'd1;
    end else if (32'(row_count) > MAX_ROWS) begin
      rows_used = 7'(MAX_ROWS);
    end else begin
      rows_used = row_count;
    end
    if (column_count == 7'd0) begin
      cols_used = 7'd1;
    end else if (32'(column_count) > MAX_COLUMNS) begin
      cols_used = 7'(MAX_COLUMNS);
    end else begin
      cols_used = column_count;
    end
  end

  assign cfg_restart = cfg_valid &&
                       (cfg_index == satrs_pkg::REG_ROW_COUNT ||
                        cfg_index == satrs_pkg::REG_COLUMN_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= 7'd64;
      column_count <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == satrs_pkg::REG_ROW_COUNT) begin
        row_count <= cfg_data;
      end
      if (cfg_index == satrs_pkg::REG_COLUMN_COUNT) begin
        column_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_func   <= in_func;
      item_elem   <= in_data[15:0];
      item_top    <= in_data[21:16];
      item_left   <= in_data[27:22];
      item_bottom <= in_data[33:28];
      item_right  <= in_data[39:34];
    end
  end

  // read address; a coordinate on the zero border suppresses the data
  always_comb begin
    rd_row    = {1'b0, item_bottom};
    rd_col    = {1'b0, item_right};
    rd_border = 1'b0;
    case (cmd.rd_sel)
      satrs_pkg::RD_ABOVE: begin
        rd_row    = load_row - 7'd1;
        rd_col    = load_column;
        rd_border = (load_row == 7'd0);
      end
      satrs_pkg::RD_BR: begin
        rd_row = {1'b0, item_bottom};
        rd_col = {1'b0, item_right};
      end
      satrs_pkg::RD_TR: begin
        rd_row    = {1'b0, item_top} - 7'd1;
        rd_col    = {1'b0, item_right};
        rd_border = (item_top == 6'd0);
      end
      satrs_pkg::RD_BL: begin
        rd_row    = {1'b0, item_bottom};
        rd_col    = {1'b0, item_left} - 7'd1;
        rd_border = (item_left == 6'd0);
      end
      satrs_pkg::RD_TL: begin
        rd_row    = {1'b0, item_top} - 7'd1;
        rd_col    = {1'b0, item_left} - 7'd1;
        rd_border = (item_top == 6'd0) || (item_left == 6'd0);
      end
      default: begin
        rd_border = 1'b1;
      end
    endcase
  end

  assign rd_addr = {RowAw'(rd_row), ColAw'(rd_col)};
  assign wr_addr = {RowAw'(load_row), ColAw'(load_column)};

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_zero <= rd_border;
    end
  end

  assign rd_value = rd_zero ? 32'd0 : rd_data;

  assign elem_ext = {{16{item_elem[15]}}, item_elem};
  assign rrs_sum  = row_running_sum + elem_ext;
  assign wr_data  = rd_value + rrs_sum;
  assign col_inc  = load_column + 7'd1;
  assign row_inc  = load_row + 7'd1;

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      load_row        <= 7'd0;
      load_column     <= 7'd0;
      row_running_sum <= 32'd0;
      table_full      <= 1'b0;
    end else if (cmd.load_wr) begin
      if (col_inc >= cols_used) begin
        load_column     <= 7'd0;
        row_running_sum <= 32'd0;
        load_row        <= row_inc;
        if (row_inc >= rows_used) begin
          table_full <= 1'b1;
        end
      end else begin
        load_column     <= col_inc;
        row_running_sum <= rrs_sum;
      end
    end
  end

  assign rect_bad = (item_top > item_bottom) || (item_left > item_right) ||
                    ({1'b0, item_bottom} >= rows_used) ||
                    ({1'b0, item_right} >= cols_used);

  always_comb begin
    if (!table_full) begin
      q_status = satrs_pkg::STATUS_NOT_LOADED;
    end else if (rect_bad) begin
      q_status = satrs_pkg::STATUS_BAD_RECT;
    end else begin
      q_status = satrs_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      satrs_pkg::ACC_SET: acc <= rd_value;
      satrs_pkg::ACC_SUB: acc <= acc - rd_value;
      satrs_pkg::ACC_ADD: acc <= acc + rd_value;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sum    <= (q_status == satrs_pkg::STATUS_OK) ? acc : 32'd0;
      out_status <= q_status;
    end
  end

  assign out_data = {6'd0, out_status, out_sum};

  assign stat.is_query = (item_func == satrs_pkg::FUNC_QUERY);
  assign stat.load_ok  = !table_full && (load_row < rows_used) &&
                         (load_column < cols_used);
  assign stat.query_ok = (q_status == satrs_pkg::STATUS_OK);
  assign stat.out_free = !out_valid || out_ready;

endmodule
